// ===== hdl/smka_pkg.sv =====
// ----------------------------------------------------------------------------
// smka_pkg
// Shared types and constants for the stick-to-menu-keys auto-repeat unit:
// key codes, axis direction codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package smka_pkg;

    // Default parameter values
    localparam int AXIS_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int KEY_W       = 3;
    localparam int ELAPSED_W   = 16;
    localparam int THRESHOLD_W = 15;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int MAX_KEYS    = 4;
    localparam int KEY_CNT_W   = 3;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_UP     = 3'd0;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 3'd1;
    localparam logic [KEY_W-1:0] KEY_LEFT   = 3'd2;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 3'd3;
    localparam logic [KEY_W-1:0] KEY_ENTER  = 3'd4;
    localparam logic [KEY_W-1:0] KEY_ESCAPE = 3'd5;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_THRESHOLD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_REPEAT_MS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_MS         = 2'd2;

    // Register reset values
    localparam logic [THRESHOLD_W-1:0] AXIS_THRESHOLD_RST    = 15'd18022;
    localparam logic [CFG_DATA_W-1:0]  INITIAL_REPEAT_MS_RST = 16'd350;
    localparam logic [CFG_DATA_W-1:0]  REPEAT_MS_RST         = 16'd120;

    // Axis direction
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } t_dir;

    // Key slots of one poll
    typedef logic [MAX_KEYS-1:0][KEY_W-1:0] t_key_slots;

endpackage

// ===== hdl/stick_to_menu_keys_autorepeat_unit.sv =====
// ----------------------------------------------------------------------------
// stick_to_menu_keys_autorepeat_unit
// Turns one controller poll into up to four menu key transactions
// (vertical, horizontal, enter, escape) with typematic auto-repeat.
// ----------------------------------------------------------------------------
// Each accepted poll is evaluated in the cycle it is accepted: axis
// directions, repeat timers and button history are updated at once and the
// keys it produces are packed into a pending register. From there they move
// to the output register and leave one key per cycle while i_stall is low,
// the final key of a poll flagged by o_last. A poll is accepted every cycle
// as long as the output keeps pace, so a poll producing n keys occupies the
// output for n key transfers (one to four; a poll producing no key puts
// nothing at the output). With the output idle, the first key of a poll
// passes the pending register and then the output register before it is
// offered. The one-key-per-cycle output register sets the sustained rate;
// the pending register lets the next poll enter while the current one drains.
module stick_to_menu_keys_autorepeat_unit #(
    parameter int AXIS_WIDTH = smka_pkg::AXIS_WIDTH_DEF,
    parameter int TIME_WIDTH = smka_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [smka_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [smka_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    // poll channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [smka_pkg::ELAPSED_W-1:0]       i_elapsed_ms,
    input  logic                                 i_session_accepts,
    input  logic                                 i_menu_active,
    input  logic                                 i_left_connected,
    input  logic                                 i_right_connected,
    input  logic signed [AXIS_WIDTH-1:0]         i_stick_x,
    input  logic signed [AXIS_WIDTH-1:0]         i_stick_y,
    input  logic                                 i_right_primary,
    input  logic                                 i_right_secondary,
    input  logic                                 i_left_menu,
    input  logic                                 i_right_menu,

    // key channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [smka_pkg::KEY_W-1:0]           o_key_code,
    output logic                                 o_last
);

    // signed compare width: holds the stick value and the negated threshold
    localparam int SW = ((AXIS_WIDTH > smka_pkg::THRESHOLD_W) ?
                         AXIS_WIDTH : smka_pkg::THRESHOLD_W) + 2;
    // elapsed compare width
    localparam int CW = (TIME_WIDTH > smka_pkg::ELAPSED_W) ?
                        TIME_WIDTH : smka_pkg::ELAPSED_W;

    typedef struct packed {
        smka_pkg::t_dir          dir;
        logic [TIME_WIDTH-1:0]   timer;
        logic                    emit;
        logic                    neg;
    } t_axis_res;

    function automatic t_axis_res f_axis(
        input logic signed [SW-1:0]           value,
        input logic signed [SW-1:0]           thr,
        input smka_pkg::t_dir                 dir,
        input logic [TIME_WIDTH-1:0]          timer,
        input logic [CW-1:0]                  elapsed,
        input logic [TIME_WIDTH-1:0]          init_ms,
        input logic [TIME_WIDTH-1:0]          rep_ms
    );
        smka_pkg::t_dir          nxt;
        logic [TIME_WIDTH-1:0]   left;
        t_axis_res               res;
        if (value > thr) begin
            nxt = smka_pkg::DIR_POS;
        end else if (value < -thr) begin
            nxt = smka_pkg::DIR_NEG;
        end else begin
            nxt = smka_pkg::DIR_NONE;
        end
        res.dir   = nxt;
        res.neg   = (nxt == smka_pkg::DIR_NEG);
        res.emit  = 1'b0;
        res.timer = timer;
        left      = '0;
        if (nxt == smka_pkg::DIR_NONE) begin
            res.timer = '0;
        end else if (nxt != dir) begin
            res.emit  = 1'b1;
            res.timer = init_ms;
        end else begin
            // count down, saturating at zero; no residue into the reload
            if (elapsed >= CW'(timer)) begin
                left = '0;
            end else begin
                left = TIME_WIDTH'(CW'(timer) - elapsed);
            end
            if (left == '0) begin
                res.emit  = 1'b1;
                res.timer = rep_ms;
            end else begin
                res.timer = left;
            end
        end
        return res;
    endfunction

    // configuration
    logic [smka_pkg::THRESHOLD_W-1:0] r_axis_threshold;
    logic [smka_pkg::CFG_DATA_W-1:0]  r_initial_repeat_ms;
    logic [smka_pkg::CFG_DATA_W-1:0]  r_repeat_ms;

    // poll state
    smka_pkg::t_dir          r_vert_dir, n_vert_dir;
    smka_pkg::t_dir          r_horz_dir, n_horz_dir;
    logic [TIME_WIDTH-1:0]   r_vert_timer, n_vert_timer;
    logic [TIME_WIDTH-1:0]   r_horz_timer, n_horz_timer;
    logic                    r_prev_primary, r_prev_secondary;
    logic                    r_prev_menu_left, r_prev_menu_right;

    // key buffers
    smka_pkg::t_key_slots                r_pend_key, n_pend_key;
    logic [smka_pkg::KEY_CNT_W-1:0]      r_pend_cnt, n_pend_cnt;
    smka_pkg::t_key_slots                r_out_key;
    logic [smka_pkg::KEY_CNT_W-1:0]      r_out_left;

    logic                    accept, pop, out_free, move;
    logic                    btn_a, btn_b, btn_ml, btn_mr, enabled;
    logic signed [SW-1:0]    thr_s, val_x, val_y;
    logic [CW-1:0]           elapsed;
    t_axis_res               vert_res, horz_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_threshold    <= smka_pkg::AXIS_THRESHOLD_RST;
            r_initial_repeat_ms <= smka_pkg::INITIAL_REPEAT_MS_RST;
            r_repeat_ms         <= smka_pkg::REPEAT_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                smka_pkg::CFG_AXIS_THRESHOLD: begin
                    r_axis_threshold <= i_cfg_data[smka_pkg::THRESHOLD_W-1:0];
                end
                smka_pkg::CFG_INITIAL_REPEAT_MS: begin
                    r_initial_repeat_ms <= i_cfg_data;
                end
                smka_pkg::CFG_REPEAT_MS: begin
                    r_repeat_ms <= i_cfg_data;
                end
                default: begin
                    // unknown index: ignore
                end
            endcase
        end
    end

    // handshake
    assign o_valid    = (r_out_left != '0);
    assign pop        = o_valid && !i_stall;
    assign out_free   = (r_out_left == '0) ||
                        (pop && (r_out_left == smka_pkg::KEY_CNT_W'(1)));
    assign move       = (r_pend_cnt != '0) && out_free;
    assign o_stall    = (r_pend_cnt != '0) && !out_free;
    assign accept     = i_valid && !o_stall;
    assign o_key_code = r_out_key[0];
    assign o_last     = (r_out_left == smka_pkg::KEY_CNT_W'(1));

    // poll evaluation
    assign btn_a   = i_right_connected && i_right_primary;
    assign btn_b   = i_right_connected && i_right_secondary;
    assign btn_ml  = i_left_connected && i_left_menu;
    assign btn_mr  = i_right_connected && i_right_menu;
    assign enabled = i_menu_active && i_session_accepts;

    assign thr_s   = SW'(r_axis_threshold);
    assign val_x   = i_left_connected ? SW'(i_stick_x) : '0;
    assign val_y   = i_left_connected ? SW'(i_stick_y) : '0;
    assign elapsed = CW'(i_elapsed_ms) & CW'({TIME_WIDTH{1'b1}});

    assign vert_res = f_axis(val_y, thr_s, r_vert_dir, r_vert_timer, elapsed,
                             TIME_WIDTH'(r_initial_repeat_ms),
                             TIME_WIDTH'(r_repeat_ms));
    assign horz_res = f_axis(val_x, thr_s, r_horz_dir, r_horz_timer, elapsed,
                             TIME_WIDTH'(r_initial_repeat_ms),
                             TIME_WIDTH'(r_repeat_ms));

    always_comb begin
        n_vert_dir   = smka_pkg::DIR_NONE;
        n_horz_dir   = smka_pkg::DIR_NONE;
        n_vert_timer = '0;
        n_horz_timer = '0;
        n_pend_key   = '0;
        n_pend_cnt   = '0;
        if (enabled) begin
            n_vert_dir   = vert_res.dir;
            n_horz_dir   = horz_res.dir;
            n_vert_timer = vert_res.timer;
            n_horz_timer = horz_res.timer;
            // append keys in order: vertical, horizontal, enter, escape
            if (vert_res.emit) begin
                n_pend_key[n_pend_cnt[1:0]] = vert_res.neg ? smka_pkg::KEY_DOWN
                                                           : smka_pkg::KEY_UP;
                n_pend_cnt = n_pend_cnt + smka_pkg::KEY_CNT_W'(1);
            end
            if (horz_res.emit) begin
                n_pend_key[n_pend_cnt[1:0]] = horz_res.neg ? smka_pkg::KEY_LEFT
                                                           : smka_pkg::KEY_RIGHT;
                n_pend_cnt = n_pend_cnt + smka_pkg::KEY_CNT_W'(1);
            end
            if (btn_a && !r_prev_primary) begin
                n_pend_key[n_pend_cnt[1:0]] = smka_pkg::KEY_ENTER;
                n_pend_cnt = n_pend_cnt + smka_pkg::KEY_CNT_W'(1);
            end
            if ((btn_b && !r_prev_secondary) || (btn_ml && !r_prev_menu_left) ||
                (btn_mr && !r_prev_menu_right)) begin
                n_pend_key[n_pend_cnt[1:0]] = smka_pkg::KEY_ESCAPE;
                n_pend_cnt = n_pend_cnt + smka_pkg::KEY_CNT_W'(1);
            end
        end
    end

    // poll state advances only on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vert_dir        <= smka_pkg::DIR_NONE;
            r_horz_dir        <= smka_pkg::DIR_NONE;
            r_vert_timer      <= '0;
            r_horz_timer      <= '0;
            r_prev_primary    <= 1'b0;
            r_prev_secondary  <= 1'b0;
            r_prev_menu_left  <= 1'b0;
            r_prev_menu_right <= 1'b0;
        end else if (accept) begin
            r_vert_dir        <= n_vert_dir;
            r_horz_dir        <= n_horz_dir;
            r_vert_timer      <= n_vert_timer;
            r_horz_timer      <= n_horz_timer;
            r_prev_primary    <= btn_a;
            r_prev_secondary  <= btn_b;
            r_prev_menu_left  <= btn_ml;
            r_prev_menu_right <= btn_mr;
        end
    end

    // pending register: load on accept, drop once handed to the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
        end else if (accept) begin
            r_pend_cnt <= n_pend_cnt;
        end else if (move) begin
            r_pend_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_key <= n_pend_key;
        end
    end

    // output register: load a whole poll, then shift one key out per pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_left <= '0;
        end else if (move) begin
            r_out_left <= r_pend_cnt;
        end else if (pop) begin
            r_out_left <= r_out_left - smka_pkg::KEY_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_key <= r_pend_key;
        end else if (pop) begin
            r_out_key <= {smka_pkg::KEY_W'(0), r_out_key[smka_pkg::MAX_KEYS-1:1]};
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stick-to-menu-keys auto-repeat unit. Polls are
// sent in bursts with random gaps while the key side stalls on a pattern of
// its own. Every accepted poll runs through a local predictor of directions,
// repeat timers and button history. Each key transaction is checked in
// order against the expected keys. Directed polls cover threshold
// boundaries, reversal, saturation, button edges, gating and register
// extremes; random polls then run under several register settings.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_POLLS  = 47;
    localparam logic [smka_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [smka_pkg::ELAPSED_W-1:0] elapsed_ms;
        logic                 session_accepts;
        logic                 menu_active;
        logic                 left_connected;
        logic                 right_connected;
        logic signed [15:0]   stick_x;
        logic signed [15:0]   stick_y;
        logic                 right_primary;
        logic                 right_secondary;
        logic                 left_menu;
        logic                 right_menu;
    } t_poll;

    typedef struct packed {
        logic [smka_pkg::KEY_W-1:0] key;
        logic             is_last;
    } t_key_evt;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [smka_pkg::CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [smka_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [smka_pkg::ELAPSED_W-1:0]    i_elapsed_ms = '0;
    logic                    i_session_accepts = 1'b0;
    logic                    i_menu_active = 1'b0;
    logic                    i_left_connected = 1'b0;
    logic                    i_right_connected = 1'b0;
    logic signed [15:0]      i_stick_x = '0;
    logic signed [15:0]      i_stick_y = '0;
    logic                    i_right_primary = 1'b0;
    logic                    i_right_secondary = 1'b0;
    logic                    i_left_menu = 1'b0;
    logic                    i_right_menu = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [smka_pkg::KEY_W-1:0]        o_key_code;
    logic                    o_last;

    stick_to_menu_keys_autorepeat_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_elapsed_ms      (i_elapsed_ms),
        .i_session_accepts (i_session_accepts),
        .i_menu_active     (i_menu_active),
        .i_left_connected  (i_left_connected),
        .i_right_connected (i_right_connected),
        .i_stick_x         (i_stick_x),
        .i_stick_y         (i_stick_y),
        .i_right_primary   (i_right_primary),
        .i_right_secondary (i_right_secondary),
        .i_left_menu       (i_left_menu),
        .i_right_menu      (i_right_menu),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_key_code        (o_key_code),
        .o_last            (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state
    logic [smka_pkg::THRESHOLD_W-1:0] axis_threshold = smka_pkg::AXIS_THRESHOLD_RST;
    logic [15:0]            initial_repeat_ms = smka_pkg::INITIAL_REPEAT_MS_RST;
    logic [15:0]            repeat_ms         = smka_pkg::REPEAT_MS_RST;
    smka_pkg::t_dir         vert_dir   = smka_pkg::DIR_NONE;
    smka_pkg::t_dir         horiz_dir  = smka_pkg::DIR_NONE;
    logic [15:0]            vert_timer  = '0;
    logic [15:0]            horiz_timer = '0;
    logic                   prev_primary   = 1'b0;
    logic                   prev_secondary = 1'b0;
    logic                   prev_menu_left  = 1'b0;
    logic                   prev_menu_right = 1'b0;

    t_key_evt    pending_keys[$];
    int          mismatches = 0;

    // Random stimulus state: held stick and buttons
    logic signed [15:0] held_x = '0;
    logic signed [15:0] held_y = '0;
    logic [3:0]         held_buttons = '0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Return the direction whose key fires on this poll, DIR_NONE for none
    function automatic smka_pkg::t_dir advance_axis(
        input int value, input logic [15:0] elapsed,
        inout smka_pkg::t_dir dir, inout logic [15:0] timer);
        int             limit;
        smka_pkg::t_dir next;
        limit = int'(axis_threshold);
        if (value > limit)
            next = smka_pkg::DIR_POS;
        else if (value < -limit)
            next = smka_pkg::DIR_NEG;
        else
            next = smka_pkg::DIR_NONE;
        if (next == smka_pkg::DIR_NONE) begin
            dir = smka_pkg::DIR_NONE;
            timer = '0;
            return smka_pkg::DIR_NONE;
        end
        if (next != dir) begin
            dir = next;
            timer = initial_repeat_ms;
            return next;
        end
        // Saturate at zero; no residue carried into the reload
        timer = (elapsed >= timer) ? 16'd0 : timer - elapsed;
        if (timer == 16'd0) begin
            timer = repeat_ms;
            return next;
        end
        return smka_pkg::DIR_NONE;
    endfunction

    function automatic void predict_keys(input t_poll p);
        logic [smka_pkg::KEY_W-1:0] keys[$];
        logic             a, b, ml, mr;
        int               sx, sy;
        smka_pkg::t_dir   fire;
        t_key_evt         evt;
        a  = p.right_connected & p.right_primary;
        b  = p.right_connected & p.right_secondary;
        ml = p.left_connected & p.left_menu;
        mr = p.right_connected & p.right_menu;
        if (!p.menu_active || !p.session_accepts) begin
            vert_dir = smka_pkg::DIR_NONE;
            horiz_dir = smka_pkg::DIR_NONE;
            vert_timer = '0;
            horiz_timer = '0;
        end else begin
            sx = p.left_connected ? int'(p.stick_x) : 0;
            sy = p.left_connected ? int'(p.stick_y) : 0;
            fire = advance_axis(sy, p.elapsed_ms, vert_dir, vert_timer);
            if (fire == smka_pkg::DIR_POS)
                keys = {keys, smka_pkg::KEY_UP};
            else if (fire == smka_pkg::DIR_NEG)
                keys = {keys, smka_pkg::KEY_DOWN};
            fire = advance_axis(sx, p.elapsed_ms, horiz_dir, horiz_timer);
            if (fire == smka_pkg::DIR_POS)
                keys = {keys, smka_pkg::KEY_RIGHT};
            else if (fire == smka_pkg::DIR_NEG)
                keys = {keys, smka_pkg::KEY_LEFT};
            if (a && !prev_primary)
                keys = {keys, smka_pkg::KEY_ENTER};
            if ((b && !prev_secondary) || (ml && !prev_menu_left) || (mr && !prev_menu_right))
                keys = {keys, smka_pkg::KEY_ESCAPE};
        end
        prev_primary = a;
        prev_secondary = b;
        prev_menu_left = ml;
        prev_menu_right = mr;
        foreach (keys[k]) begin
            evt.key = keys[k];
            evt.is_last = (k == keys.size() - 1);
            pending_keys = {pending_keys, evt};
        end
    endfunction

    // Check each key transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_key_evt want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_keys.size() == 0) begin
                report_mismatch($sformatf("unexpected key %0d last %0b", o_key_code, o_last));
            end else begin
                want = pending_keys.pop_front();
                if (o_key_code !== want.key)
                    report_mismatch($sformatf("key %0d, expected %0d", o_key_code, want.key));
                if (o_last !== want.is_last)
                    report_mismatch($sformatf("last %0b, expected %0b", o_last, want.is_last));
            end
        end
    end

    // Key-side stall pattern: stretches of none, light and heavy stalling
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 2));
            stall_left <= $urandom_range(10, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 2) == 0);
            default:     i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Drive one poll and hold it until the transaction is accepted
    task automatic send_poll(input t_poll p);
        i_valid           <= 1'b1;
        i_elapsed_ms      <= p.elapsed_ms;
        i_session_accepts <= p.session_accepts;
        i_menu_active     <= p.menu_active;
        i_left_connected  <= p.left_connected;
        i_right_connected <= p.right_connected;
        i_stick_x         <= p.stick_x;
        i_stick_y         <= p.stick_y;
        i_right_primary   <= p.right_primary;
        i_right_secondary <= p.right_secondary;
        i_left_menu       <= p.left_menu;
        i_right_menu      <= p.right_menu;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_keys(p);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Hold off until every expected key is out, then let a silent poll settle
    task automatic wait_all_keys(input int settle);
        i_valid <= 1'b0;
        while (pending_keys.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [smka_pkg::CFG_INDEX_W-1:0] index,
                             input logic [smka_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            smka_pkg::CFG_AXIS_THRESHOLD:
                axis_threshold = data[smka_pkg::THRESHOLD_W-1:0];
            smka_pkg::CFG_INITIAL_REPEAT_MS: initial_repeat_ms = data;
            smka_pkg::CFG_REPEAT_MS:         repeat_ms = data;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [smka_pkg::CFG_DATA_W-1:0] threshold,
                                input logic [smka_pkg::CFG_DATA_W-1:0] initial_ms,
                                input logic [smka_pkg::CFG_DATA_W-1:0] period_ms);
        wait_all_keys(SETTLE_CYCLES);
        write_reg(smka_pkg::CFG_AXIS_THRESHOLD, threshold);
        write_reg(smka_pkg::CFG_INITIAL_REPEAT_MS, initial_ms);
        write_reg(smka_pkg::CFG_REPEAT_MS, period_ms);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_poll engaged_poll();
        t_poll p;
        p = '0;
        p.session_accepts = 1'b1;
        p.menu_active = 1'b1;
        p.left_connected = 1'b1;
        p.right_connected = 1'b1;
        p.elapsed_ms = 16'd16;
        return p;
    endfunction

    function automatic logic signed [15:0] random_axis();
        logic [15:0] thr;
        thr = {1'b0, axis_threshold};
        case ($urandom_range(0, 7))
            0: return thr;
            1: return thr + 16'd1;
            2: return -thr;
            3: return -thr - 16'd1;
            4: return 16'sh7FFF;
            5: return 16'sh8000;
            6: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_poll random_poll();
        t_poll p;
        int    pick;
        p = engaged_poll();
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            // Noise: every field at random
            p.elapsed_ms = 16'($urandom);
            {p.session_accepts, p.menu_active, p.left_connected, p.right_connected} =
                4'($urandom);
            p.stick_x = 16'($urandom);
            p.stick_y = 16'($urandom);
            {p.right_primary, p.right_secondary, p.left_menu, p.right_menu} = 4'($urandom);
            return p;
        end
        if ($urandom_range(0, 5) == 0)
            held_x = random_axis();
        if ($urandom_range(0, 5) == 0)
            held_y = random_axis();
        held_buttons = held_buttons ^ (4'($urandom) & 4'($urandom));
        p.stick_x = held_x;
        p.stick_y = held_y;
        {p.right_primary, p.right_secondary, p.left_menu, p.right_menu} = held_buttons;
        p.session_accepts = ($urandom_range(0, 19) != 0);
        p.menu_active = ($urandom_range(0, 19) != 0);
        p.left_connected = ($urandom_range(0, 9) != 0);
        p.right_connected = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            p.elapsed_ms = 16'($urandom_range(0, 150));
        else if (pick < 9)
            p.elapsed_ms = 16'($urandom_range(0, 400));
        else
            p.elapsed_ms = 16'($urandom);
        return p;
    endfunction

    task automatic test_axis_repeat();
        t_poll p;
        p = engaged_poll();
        send_poll(p);
        // Exactly at the threshold: no direction
        p.stick_y = 16'sd18022;
        p.stick_x = -16'sd18022;
        send_poll(p);
        p.stick_y = 16'sd18023;
        p.stick_x = -16'sd18023;
        send_poll(p);
        p.elapsed_ms = 16'd349;
        send_poll(p);
        // Elapsed well past the timer: saturate and repeat
        p.elapsed_ms = 16'hFFFF;
        send_poll(p);
        // Reversal straight across zero
        p.elapsed_ms = 16'd16;
        p.stick_y = 16'sh8000;
        p.stick_x = 16'sh7FFF;
        send_poll(p);
    endtask

    task automatic test_buttons_and_gating();
        t_poll p;
        p = engaged_poll();
        p.right_primary = 1'b1;
        p.right_secondary = 1'b1;
        send_poll(p);
        send_poll(p);
        p.right_primary = 1'b0;
        p.right_secondary = 1'b0;
        send_poll(p);
        p.left_menu = 1'b1;
        send_poll(p);
        p.right_menu = 1'b1;
        send_poll(p);
        // Menu hidden: clear directions, capture history
        p.left_menu = 1'b0;
        p.right_menu = 1'b0;
        p.menu_active = 1'b0;
        p.right_primary = 1'b1;
        p.stick_y = 16'sh7FFF;
        send_poll(p);
        p.menu_active = 1'b1;
        send_poll(p);
        p.session_accepts = 1'b0;
        send_poll(p);
        // Left side gone: stick and its menu button do not count
        p.session_accepts = 1'b1;
        p.right_primary = 1'b0;
        p.left_connected = 1'b0;
        p.left_menu = 1'b1;
        p.stick_x = 16'sh8000;
        send_poll(p);
        p.right_connected = 1'b0;
        p.right_primary = 1'b1;
        send_poll(p);
        p.right_connected = 1'b1;
        send_poll(p);
    endtask

    task automatic test_register_extremes();
        t_poll p;
        wait_all_keys(SETTLE_CYCLES);
        // An index past the list must be ignored; threshold data is masked
        write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        i_cfg_we <= 1'b0;
        program_regs(16'hFFFF, 16'd0, 16'd0);
        p = engaged_poll();
        p.stick_y = 16'sh7FFF;
        send_poll(p);
        p.stick_y = 16'sh8000;
        send_poll(p);
        // Zero period: repeat on every poll, even with no time elapsed
        p.elapsed_ms = 16'd0;
        send_poll(p);
        program_regs(16'd0, 16'hFFFF, 16'hFFFF);
        p = engaged_poll();
        p.stick_x = 16'sd1;
        send_poll(p);
        p.stick_x = -16'sd1;
        send_poll(p);
        p.stick_x = 16'sd0;
        send_poll(p);
        p.stick_x = 16'sd1;
        send_poll(p);
        p.elapsed_ms = 16'hFFFF;
        send_poll(p);
    endtask

    task automatic run_random_phase(input int polls);
        t_poll p;
        int    sent;
        int    burst;
        sent = 0;
        while (sent < polls) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                if (sent < polls) begin
                    p = random_poll();
                    send_poll(p);
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    task automatic test_random_traffic();
        program_regs({1'b0, smka_pkg::AXIS_THRESHOLD_RST},
                     smka_pkg::INITIAL_REPEAT_MS_RST, smka_pkg::REPEAT_MS_RST);
        run_random_phase(PHASE_POLLS);
        program_regs(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 300)),
                     16'($urandom_range(0, 150)));
        run_random_phase(PHASE_POLLS);
        program_regs(16'd0, 16'hFFFF, 16'hFFFF);
        run_random_phase(PHASE_POLLS);
        program_regs(16'h7FFF, 16'd0, 16'd0);
        run_random_phase(PHASE_POLLS);
        program_regs(16'($urandom), 16'($urandom), 16'($urandom));
        run_random_phase(PHASE_POLLS);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_axis_repeat();
        test_buttons_and_gating();
        test_register_extremes();
        test_random_traffic();
        wait_all_keys(2 * SETTLE_CYCLES);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TIMEOUT with %0d keys outstanding", pending_keys.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
